FILE: design/integer_to_ascii_digits_unit_assert.svh
// Assertion macros shared by the integer to ASCII digits unit.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef INTEGER_TO_ASCII_DIGITS_UNIT_ASSERT_SVH
`define INTEGER_TO_ASCII_DIGITS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ITOA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ITOA_ASSERT_NEVER(lbl, cond, msg) \
  `ITOA_ASSERT(lbl, !(cond), msg)
`else
`define ITOA_ASSERT(lbl, prop, msg)
`define ITOA_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: design/itoa_pkg.sv
// Package of the integer to ASCII digits unit: widths, character codes,
// state types, the converter handoff struct and the digit glyph function.
package itoa_pkg;

  localparam int unsigned ValueWidth        = 64;
  localparam int unsigned DigitWidth        = 4;
  localparam int unsigned CharWidth         = 7;
  localparam int unsigned DefaultDigitDepth = 32;

  localparam logic [CharWidth-1:0] CharZero   = 7'h30;
  localparam logic [CharWidth-1:0] CharNine   = 7'h39;
  localparam logic [CharWidth-1:0] CharLowerA = 7'h61;
  localparam logic [CharWidth-1:0] CharLowerF = 7'h66;
  localparam logic [CharWidth-1:0] CharMinus  = 7'h2D;

  localparam logic [DigitWidth-1:0] DecimalLimit = 4'd10;

  typedef enum logic [1:0] {
    ConvIdle,
    ConvShift,
    ConvDone
  } conv_state_e;

  typedef enum logic [1:0] {
    EmitIdle,
    EmitSkip,
    EmitOut
  } emit_state_e;

  // Control travelling from the converter to the emitter with the digits.
  typedef struct packed {
    logic valid;
    logic neg;
  } handoff_t;

  // Maps one digit value to its lowercase ASCII glyph.
  function automatic logic [CharWidth-1:0] glyph(input logic [DigitWidth-1:0] d);
    logic [CharWidth-1:0] g;
    if (d < DecimalLimit) begin
      g = CharZero + {3'b000, d};
    end else begin
      g = CharLowerA + {3'b000, d - DecimalLimit};
    end
    return g;
  endfunction

endpackage

FILE: design/itoa_conv.sv
// Bit-serial converter: shift-and-add-3 binary to decimal digits, one input
// bit per cycle, or a direct nibble load for hex. Depends on itoa_pkg.
module itoa_conv #(
  parameter int unsigned DIGIT_STORE_DEPTH = itoa_pkg::DefaultDigitDepth
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  output logic                                      ready_o,
  input  logic [itoa_pkg::ValueWidth-1:0]           value_i,
  input  logic                                      hex_i,
  input  logic                                      neg_i,
  output itoa_pkg::handoff_t                        hand_o,
  output logic [DIGIT_STORE_DEPTH*itoa_pkg::DigitWidth-1:0] digits_o,
  input  logic                                      take_i
);
  import itoa_pkg::*;

  localparam int unsigned DigW  = DIGIT_STORE_DEPTH * DigitWidth;
  localparam int unsigned CntW  = $clog2(ValueWidth);
  localparam logic [CntW-1:0] LastBit = CntW'(ValueWidth - 1);

  conv_state_e           state_q, state_d;
  logic [ValueWidth-1:0] bin_q, bin_d;
  logic [DigW-1:0]       bcd_q, bcd_d;
  logic [DigW-1:0]       adj;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  neg_q, neg_d;
  logic [ValueWidth-1:0] mag;

  // Two's complement magnitude of a negative input.
  assign mag = neg_i ? (~value_i + 1'b1) : value_i;

  // The converter takes a new value only while idle.
  assign ready_o = (state_q == ConvIdle);

  // Add 3 to every digit that is 5 or more before the next shift.
  always_comb begin
    for (int k = 0; k < DIGIT_STORE_DEPTH; k++) begin
      adj[k*DigitWidth +: DigitWidth] = (bcd_q[k*DigitWidth +: DigitWidth] >= 4'd5) ?
          bcd_q[k*DigitWidth +: DigitWidth] + 4'd3 : bcd_q[k*DigitWidth +: DigitWidth];
    end
  end

  // Next state and datapath of the converter.
  always_comb begin
    state_d = state_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    hand_o  = '0;
    unique case (state_q)
      ConvIdle: begin
        if (start_i) begin
          neg_d = neg_i;
          cnt_d = '0;
          if (hex_i) begin
            bcd_d   = {{(DigW-ValueWidth){1'b0}}, mag};
            state_d = ConvDone;
          end else begin
            bin_d   = mag;
            bcd_d   = '0;
            state_d = ConvShift;
          end
        end
      end
      ConvShift: begin
        bcd_d = {adj[DigW-2:0], bin_q[ValueWidth-1]};
        bin_d = {bin_q[ValueWidth-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastBit) begin
          state_d = ConvDone;
        end
      end
      ConvDone: begin
        hand_o.valid = 1'b1;
        hand_o.neg   = neg_q;
        if (take_i) begin
          state_d = ConvIdle;
        end
      end
      default: state_d = ConvIdle;
    endcase
  end

  assign digits_o = bcd_q;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ConvIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

endmodule

FILE: design/itoa_emit.sv
// Character emitter: skips leading zero digits, sends an optional minus and
// then one glyph per transfer from the top digit down. Depends on itoa_pkg.
module itoa_emit #(
  parameter int unsigned DIGIT_STORE_DEPTH = itoa_pkg::DefaultDigitDepth
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  itoa_pkg::handoff_t                        hand_i,
  input  logic [DIGIT_STORE_DEPTH*itoa_pkg::DigitWidth-1:0] digits_i,
  output logic                                      take_o,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic [itoa_pkg::CharWidth-1:0]            out_char_o,
  output logic                                      out_last_o
);
  import itoa_pkg::*;

  `include "integer_to_ascii_digits_unit_assert.svh"

  localparam int unsigned DigW  = DIGIT_STORE_DEPTH * DigitWidth;
  localparam int unsigned LeftW = $clog2(DIGIT_STORE_DEPTH + 1);
  localparam logic [LeftW-1:0] LeftOne  = LeftW'(1);
  localparam logic [LeftW-1:0] LeftFull = LeftW'(DIGIT_STORE_DEPTH);

  emit_state_e          state_q, state_d;
  logic [DigW-1:0]      dig_q, dig_d;
  logic [LeftW-1:0]     left_q, left_d;
  logic                 neg_q, neg_d;
  logic                 ov_q, ov_d;
  logic [CharWidth-1:0] oc_q, oc_d;
  logic                 ol_q, ol_d;
  logic [DigitWidth-1:0] top;
  logic                 char_ok;

  assign top = dig_q[DigW-1 -: DigitWidth];

  // Next state, digit shifter and output register load.
  always_comb begin
    state_d = state_q;
    dig_d   = dig_q;
    left_d  = left_q;
    neg_d   = neg_q;
    ov_d    = ov_q;
    oc_d    = oc_q;
    ol_d    = ol_q;
    take_o  = 1'b0;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    unique case (state_q)
      EmitIdle: begin
        take_o = 1'b1;
        if (hand_i.valid) begin
          dig_d   = digits_i;
          left_d  = LeftFull;
          neg_d   = hand_i.neg;
          state_d = EmitSkip;
        end
      end
      EmitSkip: begin
        if (top == '0 && left_q != LeftOne) begin
          dig_d  = {dig_q[DigW-DigitWidth-1:0], {DigitWidth{1'b0}}};
          left_d = left_q - 1'b1;
        end else begin
          state_d = EmitOut;
        end
      end
      EmitOut: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          if (neg_q) begin
            oc_d  = CharMinus;
            ol_d  = 1'b0;
            neg_d = 1'b0;
          end else begin
            oc_d   = glyph(top);
            ol_d   = (left_q == LeftOne);
            dig_d  = {dig_q[DigW-DigitWidth-1:0], {DigitWidth{1'b0}}};
            left_d = left_q - 1'b1;
            if (left_q == LeftOne) begin
              state_d = EmitIdle;
            end
          end
        end
      end
      default: state_d = EmitIdle;
    endcase
  end

  assign out_valid_o = ov_q;
  assign out_char_o  = oc_q;
  assign out_last_o  = ol_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EmitIdle;
      ov_q    <= 1'b0;
      left_q  <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      left_q  <= left_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
    neg_q <= neg_d;
    oc_q  <= oc_d;
    ol_q  <= ol_d;
  end

  // The held character is a digit, a lowercase hex letter or the minus sign.
  assign char_ok = (oc_q >= CharZero && oc_q <= CharNine) ||
                   (oc_q >= CharLowerA && oc_q <= CharLowerF) || (oc_q == CharMinus);

  // The digit counter never runs dry while a number is being worked on.
  `ITOA_ASSERT(a_left_nonzero, (state_q != EmitIdle) |-> (left_q != '0), "digit count empty")
  // A minus sign is always followed by at least one digit.
  `ITOA_ASSERT_NEVER(a_minus_not_last, ov_q && ol_q && (oc_q == CharMinus), "minus marked last")
  // Only digits, lowercase hex letters and the minus sign are sent.
  `ITOA_ASSERT(a_char_legal, ov_q |-> char_ok, "illegal character")

endmodule

FILE: design/integer_to_ascii_digits_unit.sv
// Integer to ASCII digits unit: a 64-bit value in, a run of characters out.
// Decimal conversion shifts in one input bit per cycle and hex loads the digits directly;
// the digits then pass to the emitter through a handoff, and the emitter passes leading
// zeros and then sends one character per transfer. Conversion overlaps emission: the
// converter takes a new value once its digits have been handed to the emitter.
// Reset (rst_ni low, asynchronous) empties both stages and the output register.
module integer_to_ascii_digits_unit #(
  parameter int unsigned DIGIT_STORE_DEPTH = itoa_pkg::DefaultDigitDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // [63:0] value
  input  logic [1:0]  s_axis_tuser_i,  // [0] hex_mode, [1] signed_mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [6:0] character, [7] zero
  output logic        m_axis_tlast_o   // last
);
  import itoa_pkg::*;

  localparam int unsigned DigW = DIGIT_STORE_DEPTH * DigitWidth;

  handoff_t             hand;
  logic [DigW-1:0]      digits;
  logic                 take;
  logic                 start;
  logic                 neg;
  logic [CharWidth-1:0] char_out;

  // An input transfer starts a conversion; negative only in signed mode.
  assign start = s_axis_tvalid_i && s_axis_tready_o;
  assign neg   = s_axis_tuser_i[1] && s_axis_tdata_i[ValueWidth-1];

  itoa_conv #(
    .DIGIT_STORE_DEPTH(DIGIT_STORE_DEPTH)
  ) u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .ready_o (s_axis_tready_o),
    .value_i (s_axis_tdata_i),
    .hex_i   (s_axis_tuser_i[0]),
    .neg_i   (neg),
    .hand_o  (hand),
    .digits_o(digits),
    .take_i  (take)
  );

  itoa_emit #(
    .DIGIT_STORE_DEPTH(DIGIT_STORE_DEPTH)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hand_i     (hand),
    .digits_i   (digits),
    .take_o     (take),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_char_o (char_out),
    .out_last_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, char_out};

endmodule

FILE: tb/integer_to_ascii_digits_unit_test.sv
// Testbench for integer_to_ascii_digits_unit: drives numbers in decimal and hex,
// signed and unsigned, and checks each emitted character against a table text or a
// local formatter. Depends on itoa_pkg and the unit itself; needs nothing else.
`timescale 1ns / 1ps

module integer_to_ascii_digits_unit_test;
  import itoa_pkg::*;

  localparam int unsigned DrainCycles = 200;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned RandomCount = 228;

  // One character of a printed number, as it leaves the unit.
  typedef struct packed {
    logic [CharWidth-1:0] character;
    logic                 last;
  } ascii_char_t;

  // One row of the directed table; an empty text means the formatter decides.
  typedef struct {
    logic [63:0] value;
    bit          hex;
    bit          sgn;
    string       text;
  } number_row_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i  = '0;  // [63:0] value
  logic [1:0]  s_axis_tuser_i  = '0;  // [0] hex_mode, [1] signed_mode
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;        // [6:0] character, [7] zero
  logic        m_axis_tlast_o;

  ascii_char_t pending_chars[$];
  number_row_t directed_rows[$];
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 33;
  int unsigned recv_stall_pct = 59;

  integer_to_ascii_digits_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Splits the magnitude into digits, least significant first, then queues
  // the sign and the digits most significant first.
  function automatic void format_number(input logic [63:0] value, input bit hex,
                                        input bit sgn);
    string       glyphs;
    logic [3:0]  digits[20];
    logic [63:0] magnitude;
    bit          negative;
    int          count;
    ascii_char_t c;
    glyphs    = "0123456789abcdef";
    negative  = sgn && value[63];
    magnitude = negative ? (~value + 64'd1) : value;
    count     = 0;
    do begin
      if (hex) begin
        digits[count] = magnitude[3:0];
        magnitude     = magnitude >> 4;
      end else begin
        digits[count] = 4'(magnitude % 64'd10);
        magnitude     = magnitude / 64'd10;
      end
      count++;
    end while (magnitude != 0 && count < 20);
    if (negative) begin
      c.character = CharMinus;
      c.last      = 1'b0;
      pending_chars.push_back(c);
    end
    for (int i = count - 1; i >= 0; i--) begin
      c.character = CharWidth'(glyphs[digits[i]]);
      c.last      = (i == 0);
      pending_chars.push_back(c);
    end
  endfunction

  // Offers one number, idling first at the current rate, and records what it
  // must print once the transfer has happened.
  task automatic send_number(input logic [63:0] value, input bit hex, input bit sgn,
                             input string text);
    ascii_char_t c;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tuser_i  <= {sgn, hex};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (text.len() == 0) begin
      format_number(value, hex, sgn);
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        c.character = CharWidth'(text[i]);
        c.last      = (i == text.len() - 1);
        pending_chars.push_back(c);
      end
    end
  endtask

  // Draws a random number: full width, truncated, small, negative, or near a
  // power of ten where the digit count changes.
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    logic [63:0] p;
    case ($urandom_range(4))
      0: v = {$urandom, $urandom};
      1: v = {$urandom, $urandom} >> $urandom_range(63);
      2: v = 64'($urandom_range(20));
      3: v = -({$urandom, $urandom} >> $urandom_range(63));
      default: begin
        p = 64'd1;
        repeat ($urandom_range(19)) p = p * 64'd10;
        v = p + 64'($urandom_range(2)) - 64'd1;
      end
    endcase
    return v;
  endfunction

  // Stimulus: reset, the directed table, then three random phases.
  initial begin
    logic [63:0] value;
    directed_rows.push_back('{64'd0, 1'b0, 1'b0, "0"});
    directed_rows.push_back('{64'd0, 1'b1, 1'b0, "0"});
    directed_rows.push_back('{64'd0, 1'b0, 1'b1, "0"});
    directed_rows.push_back('{64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, "18446744073709551615"});
    directed_rows.push_back('{64'hffff_ffff_ffff_ffff, 1'b1, 1'b0, "ffffffffffffffff"});
    directed_rows.push_back('{64'hffff_ffff_ffff_ffff, 1'b0, 1'b1, "-1"});
    directed_rows.push_back('{64'hffff_ffff_ffff_ffff, 1'b1, 1'b1, "-1"});
    directed_rows.push_back('{64'h8000_0000_0000_0000, 1'b0, 1'b1, "-9223372036854775808"});
    directed_rows.push_back('{64'h8000_0000_0000_0000, 1'b1, 1'b1, "-8000000000000000"});
    directed_rows.push_back('{64'h8000_0000_0000_0000, 1'b0, 1'b0, "9223372036854775808"});
    directed_rows.push_back('{64'h7fff_ffff_ffff_ffff, 1'b0, 1'b1, "9223372036854775807"});
    directed_rows.push_back('{64'h7fff_ffff_ffff_ffff, 1'b1, 1'b1, "7fffffffffffffff"});
    directed_rows.push_back('{64'd9, 1'b0, 1'b0, "9"});
    directed_rows.push_back('{64'd10, 1'b0, 1'b0, "10"});
    directed_rows.push_back('{64'd15, 1'b1, 1'b0, "f"});
    directed_rows.push_back('{64'd16, 1'b1, 1'b1, "10"});
    directed_rows.push_back('{64'hffff_ffff_ffff_fff6, 1'b0, 1'b1, "-10"});
    directed_rows.push_back('{64'd10000000000000000000, 1'b0, 1'b0, ""});
    directed_rows.push_back('{64'h0123_4567_89ab_cdef, 1'b1, 1'b0, ""});
    directed_rows.push_back('{64'hfedc_ba98_7654_3210, 1'b0, 1'b1, ""});
    directed_rows.push_back('{64'hfedc_ba98_7654_3210, 1'b1, 1'b0, ""});
    directed_rows.push_back('{64'd999, 1'b0, 1'b1, ""});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_number(directed_rows[i].value, directed_rows[i].hex, directed_rows[i].sgn,
                  directed_rows[i].text);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 33 : (phase == 1) ? 59 : 0;
      recv_stall_pct = (phase == 0) ? 59 : (phase == 1) ? 33 : 0;
      for (int n = 0; n < RandomCount / 3; n++) begin
        value = pick_value();
        send_number(value, 1'($urandom_range(1)), 1'($urandom_range(1)), "");
      end
    end
    s_axis_tvalid_i <= 1'b0;

    // Let the last numbers drain, then allow for any stray output.
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("integer_to_ascii_digits_unit test passed");
    end else begin
      $display("integer_to_ascii_digits_unit test failed");
    end
    $finish;
  end

  // The receiver stalls at the rate of the current phase.
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every character transfer is compared with the oldest one still due.
  always @(posedge clk_i) begin : char_check
    ascii_char_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_chars.size() == 0) begin
        $error("character 0x%h (last %0b) arrived with none due",
               m_axis_tdata_o[CharWidth-1:0], m_axis_tlast_o);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        if (m_axis_tdata_o[CharWidth-1:0] !== want.character) begin
          $error("character: expected 0x%h, got 0x%h", want.character,
                 m_axis_tdata_o[CharWidth-1:0]);
          mismatches++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast_o);
          mismatches++;
        end
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("integer_to_ascii_digits_unit test failed");
      $finish;
    end
  end

endmodule

FILE: filelist.f
+incdir+design
design/itoa_pkg.sv
design/itoa_conv.sv
design/itoa_emit.sv
design/integer_to_ascii_digits_unit.sv
tb/integer_to_ascii_digits_unit_test.sv
